// ----- rtl/core/cbf_pkg.sv -----
// ----------------------------------------------------------------------------
// Counting Bloom filter package
// Shared constants, register indexes and CRC helper.
// ----------------------------------------------------------------------------
package cbf_pkg;
    localparam int BUCKET_ADDR_BITS = 20;
    localparam int MAX_HASHES       = 8;
    localparam int MAX_COUNTER_BITS = 8;
    localparam int HASH_IDX_BITS    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [BUCKET_ADDR_BITS:0] BUCKET_DEPTH = (BUCKET_ADDR_BITS+1)'(1) << BUCKET_ADDR_BITS;

    localparam logic [2:0] REG_NUM_BUCKETS = 3'd0;
    localparam logic [2:0] REG_NUM_HASHES  = 3'd1;
    localparam logic [2:0] REG_HASH_SEED   = 3'd2;
    localparam logic [2:0] REG_COUNTER_BITS = 3'd3;
    localparam logic [2:0] REG_RAISE       = 3'd4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int j = 0; j < 8; j++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction
endpackage

// ----- rtl/core/cbf_mod.sv -----
// ----------------------------------------------------------------------------
// Bucket index reduction
// Restoring shift-subtract remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module cbf_mod
    import cbf_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [31:0]                 i_num,
    input  logic [BUCKET_ADDR_BITS:0]   i_den,
    output logic                        o_done,
    output logic [BUCKET_ADDR_BITS-1:0] o_rem
);
    logic [31:0]               r_num;
    logic [BUCKET_ADDR_BITS:0] r_rem;
    logic [5:0]                r_cnt;
    logic                      r_busy;
    logic [BUCKET_ADDR_BITS+1:0] n_trial;

    assign n_trial = {r_rem, r_num[31]};
    assign o_rem   = r_rem[BUCKET_ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_go && r_busy && (r_cnt == 6'd31);
            if (i_go) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (n_trial >= {1'b0, i_den})
                    r_rem <= (BUCKET_ADDR_BITS+1)'(n_trial - {1'b0, i_den});
                else
                    r_rem <= n_trial[BUCKET_ADDR_BITS:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31)
                    r_busy <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/core/counting_bloom_filter.sv -----
// Sequence: a non-final item is absorbed while idle; a final item runs, per
// hash, the bit-serial remainder unit (S_MOD, S_WAIT) and the counter
// read-modify-write (S_READ, S_UPD), stopping early when a query or
// overflow ends it; clear sweeps all 2^20 counters, one per cycle. Busy
// drops with the result. Reset is synchronous; a clearing pass follows it
// with busy high. Results are a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Counting Bloom filter
// CRC-32 hashed counters held in one synchronous memory.
// ----------------------------------------------------------------------------
module counting_bloom_filter
    import cbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_key_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_present,
    output logic        o_overflow,
    output logic [31:0] o_items_inserted
);
    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_MOD, S_WAIT, S_READ, S_UPD, S_DONE} t_state;

    logic [7:0] mem [0:(1<<BUCKET_ADDR_BITS)-1];
    logic [7:0] r_rd;

    t_state r_state;
    logic [20:0] r_nb;
    logic [3:0]  r_nh, r_cb;
    logic [30:0] r_seed, r_kseed;
    logic        r_raise;
    logic [31:0] r_crc [0:MAX_HASHES-1];
    logic        r_inkey;
    logic [31:0] r_cnt;
    logic [1:0]  r_op;
    logic [HASH_IDX_BITS:0] r_h;
    logic [BUCKET_ADDR_BITS-1:0] r_addr;
    logic [BUCKET_ADDR_BITS:0]   r_clr;
    logic        r_pres, r_ovf;

    logic [BUCKET_ADDR_BITS:0] n_m;
    logic [4:0]  n_k;
    logic [7:0]  n_mask, n_v;
    logic        mod_go, mod_done;
    logic [BUCKET_ADDR_BITS-1:0] mod_rem;
    logic [30:0] n_seed;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign n_m = (r_nb == 21'd0) ? (BUCKET_ADDR_BITS+1)'(1) :
                 ({11'd0, r_nb} > 32'(BUCKET_DEPTH)) ? BUCKET_DEPTH :
                 (BUCKET_ADDR_BITS+1)'(r_nb);
    assign n_k = (r_nh == 4'd0) ? 5'd1 : (r_nh > 4'(MAX_HASHES)) ? 5'(MAX_HASHES) : {1'b0, r_nh};
    assign n_mask = (r_cb == 4'd0) ? 8'd1 :
                    (r_cb >= 4'(MAX_COUNTER_BITS)) ? 8'((9'd1 << MAX_COUNTER_BITS) - 9'd1) :
                    8'((9'd1 << r_cb) - 9'd1);
    assign n_v  = r_rd & n_mask;
    assign mod_go = (r_state == S_MOD);
    assign n_seed = r_inkey ? r_kseed : r_seed;

    cbf_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(mod_go),
        .i_num(~r_crc[r_h[HASH_IDX_BITS-1:0]]), .i_den(n_m),
        .o_done(mod_done), .o_rem(mod_rem)
    );

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_addr];
        if (r_state == S_CLEAR)
            mem[r_clr[BUCKET_ADDR_BITS-1:0]] <= 8'd0;
        else if (r_state == S_UPD && r_op == OP_INSERT && n_v != n_mask)
            mem[r_addr] <= n_v + 8'd1;
        else if (r_state == S_UPD && r_op == OP_DELETE && n_v != 8'd0)
            mem[r_addr] <= n_v - 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_op    <= OP_INSERT;
            r_nb    <= 21'd1048576;
            r_nh    <= 4'd4;
            r_seed  <= '0;
            r_cb    <= 4'd1;
            r_raise <= 1'b0;
            r_inkey <= 1'b0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_DONE);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_NUM_BUCKETS:  r_nb    <= i_cfg_data[20:0];
                    REG_NUM_HASHES:   r_nh    <= i_cfg_data[3:0];
                    REG_HASH_SEED:    r_seed  <= i_cfg_data[30:0];
                    REG_COUNTER_BITS: r_cb    <= i_cfg_data[3:0];
                    REG_RAISE:        r_raise <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kseed <= n_seed;
                        for (int i = 0; i < MAX_HASHES; i++) begin
                            r_crc[i] <= i_byte_valid
                                ? crc_byte(r_inkey ? r_crc[i] : ~({1'b0, n_seed} + 32'(i)), i_key_byte)
                                : (r_inkey ? r_crc[i] : ~({1'b0, n_seed} + 32'(i)));
                        end
                        r_inkey <= !i_last;
                        r_op    <= i_operation;
                        r_h     <= '0;
                        r_pres  <= (i_operation == OP_QUERY);
                        r_ovf   <= 1'b0;
                        r_clr   <= '0;
                        if (i_last)
                            r_state <= (i_operation == OP_CLEAR) ? S_CLEAR : S_MOD;
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BUCKET_DEPTH - 1'b1)
                        r_state <= (r_op == OP_CLEAR) ? S_DONE : S_IDLE;
                end
                S_MOD: r_state <= S_WAIT;
                S_WAIT: if (mod_done) begin
                    r_addr  <= mod_rem;
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_UPD;
                S_UPD: begin
                    r_h <= r_h + 1'b1;
                    if (r_op == OP_INSERT && n_v == n_mask && r_raise) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_op == OP_QUERY && n_v == 8'd0) begin
                        r_pres  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= ((r_h + 1'b1) == n_k) ? S_DONE : S_MOD;
                    end
                end
                S_DONE: begin
                    o_present <= r_pres;
                    o_overflow <= r_ovf;
                    if (r_op == OP_INSERT && !r_ovf && r_cnt != 32'hFFFFFFFF) begin
                        r_cnt <= r_cnt + 32'd1; o_items_inserted <= r_cnt + 32'd1;
                    end else if (r_op == OP_DELETE && r_cnt != 32'd0) begin
                        r_cnt <= r_cnt - 32'd1; o_items_inserted <= r_cnt - 32'd1;
                    end else
                        o_items_inserted <= r_cnt;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
